// ===== design/ir_range_linearize_classify_macros.svh =====
// Assertion macros shared by the range linearizer modules.
`ifndef IR_RANGE_LINEARIZE_CLASSIFY_MACROS_SVH
`define IR_RANGE_LINEARIZE_CLASSIFY_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define IR_RLC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define IR_RLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/ir_rlc_pkg.sv =====
// Package with types, constants and segment tables of the range linearizer.
`default_nettype none

package ir_rlc_pkg;

	localparam int ADC_W   = 10;
	localparam int DIST_W  = 10;
	localparam int STAT_W  = 2;
	localparam int POS_W   = 2;
	localparam int IDX_W   = 2;
	localparam int NUM_W   = 35;
	localparam int DEN_W   = 29;
	localparam int NEG_W   = 25;
	localparam int QUO_W   = 27;
	localparam int LIM_W   = 18;
	localparam int PROD_W  = 19;
	localparam int CNT_W   = 5;
	localparam int SEG_COUNT = 6;

	typedef logic [2:0] seg_t;

	localparam longint unsigned FS_INTERNAL = 64'd1025;
	localparam longint unsigned FS_EXTERNAL = 64'd255;

	localparam longint unsigned SEG_K0 = 64'd17280238;
	localparam longint unsigned SEG_K1 = 64'd15709661;
	localparam longint unsigned SEG_K2 = 64'd17726112;
	localparam longint unsigned SEG_K3 = 64'd18600021;
	localparam longint unsigned SEG_K4 = 64'd16240725;
	localparam longint unsigned SEG_K5 = 64'd14904577;

	localparam longint unsigned SEG_C0 = 64'd6665;
	localparam longint unsigned SEG_C1 = 64'd9313;
	localparam longint unsigned SEG_C2 = 64'd5210;
	localparam longint unsigned SEG_C3 = 64'd3283;
	localparam longint unsigned SEG_C4 = 64'd10079;
	localparam longint unsigned SEG_C5 = 64'd16731;

	localparam longint unsigned SEG_L0 = 64'd54;
	localparam longint unsigned SEG_L1 = 64'd62;
	localparam longint unsigned SEG_L2 = 64'd68;
	localparam longint unsigned SEG_L3 = 64'd86;
	localparam longint unsigned SEG_L4 = 64'd139;

	localparam logic [QUO_W-1:0]  Q16_OFFSET = 27'd27525;
	localparam logic [DIST_W-1:0] DIST_MAX   = 10'd1023;

	localparam logic [STAT_W-1:0] STAT_NONE    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_DANGER  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_WARNING = 2'd2;
	localparam logic [STAT_W-1:0] STAT_OK      = 2'd3;

	localparam logic [IDX_W-1:0] REG_BOUND_OK      = 2'd0;
	localparam logic [IDX_W-1:0] REG_BOUND_WARNING = 2'd1;
	localparam logic [IDX_W-1:0] REG_BOUND_DANGER  = 2'd2;

	localparam logic [DIST_W-1:0] BOUND_OK_RESET      = 10'd30;
	localparam logic [DIST_W-1:0] BOUND_WARNING_RESET = 10'd20;
	localparam logic [DIST_W-1:0] BOUND_DANGER_RESET  = 10'd10;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PREP,
		S_WAIT,
		S_OUT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		D_IDLE,
		D_CHECK,
		D_ITER,
		D_DONE
	} div_state_t;

	typedef struct packed {
		logic idle;
		logic done;
		logic sat;
	} div_stat_t;

	// Segment threshold in hundredths of a volt times the full-scale count.
	function automatic logic [LIM_W-1:0] seg_limit_fs(input seg_t s, input logic ext);
		unique case ({ext, s})
			4'b0_000: return LIM_W'(SEG_L0 * FS_INTERNAL);
			4'b0_001: return LIM_W'(SEG_L1 * FS_INTERNAL);
			4'b0_010: return LIM_W'(SEG_L2 * FS_INTERNAL);
			4'b0_011: return LIM_W'(SEG_L3 * FS_INTERNAL);
			4'b0_100: return LIM_W'(SEG_L4 * FS_INTERNAL);
			4'b1_000: return LIM_W'(SEG_L0 * FS_EXTERNAL);
			4'b1_001: return LIM_W'(SEG_L1 * FS_EXTERNAL);
			4'b1_010: return LIM_W'(SEG_L2 * FS_EXTERNAL);
			4'b1_011: return LIM_W'(SEG_L3 * FS_EXTERNAL);
			4'b1_100: return LIM_W'(SEG_L4 * FS_EXTERNAL);
			default:  return '0;
		endcase
	endfunction

	// Numerator of the segment formula: gain times the full-scale count.
	function automatic logic [NUM_W-1:0] seg_num(input seg_t s, input logic ext);
		unique case ({ext, s})
			4'b0_000: return NUM_W'(SEG_K0 * FS_INTERNAL);
			4'b0_001: return NUM_W'(SEG_K1 * FS_INTERNAL);
			4'b0_010: return NUM_W'(SEG_K2 * FS_INTERNAL);
			4'b0_011: return NUM_W'(SEG_K3 * FS_INTERNAL);
			4'b0_100: return NUM_W'(SEG_K4 * FS_INTERNAL);
			4'b0_101: return NUM_W'(SEG_K5 * FS_INTERNAL);
			4'b1_000: return NUM_W'(SEG_K0 * FS_EXTERNAL);
			4'b1_001: return NUM_W'(SEG_K1 * FS_EXTERNAL);
			4'b1_010: return NUM_W'(SEG_K2 * FS_EXTERNAL);
			4'b1_011: return NUM_W'(SEG_K3 * FS_EXTERNAL);
			4'b1_100: return NUM_W'(SEG_K4 * FS_EXTERNAL);
			4'b1_101: return NUM_W'(SEG_K5 * FS_EXTERNAL);
			default:  return '0;
		endcase
	endfunction

	// Offset subtracted from the scaled sample: offset times the full-scale count.
	function automatic logic [NEG_W-1:0] seg_neg(input seg_t s, input logic ext);
		unique case ({ext, s})
			4'b0_000: return NEG_W'(SEG_C0 * FS_INTERNAL);
			4'b0_001: return NEG_W'(SEG_C1 * FS_INTERNAL);
			4'b0_010: return NEG_W'(SEG_C2 * FS_INTERNAL);
			4'b0_011: return NEG_W'(SEG_C3 * FS_INTERNAL);
			4'b0_100: return NEG_W'(SEG_C4 * FS_INTERNAL);
			4'b0_101: return NEG_W'(SEG_C5 * FS_INTERNAL);
			4'b1_000: return NEG_W'(SEG_C0 * FS_EXTERNAL);
			4'b1_001: return NEG_W'(SEG_C1 * FS_EXTERNAL);
			4'b1_010: return NEG_W'(SEG_C2 * FS_EXTERNAL);
			4'b1_011: return NEG_W'(SEG_C3 * FS_EXTERNAL);
			4'b1_100: return NEG_W'(SEG_C4 * FS_EXTERNAL);
			4'b1_101: return NEG_W'(SEG_C5 * FS_EXTERNAL);
			default:  return '0;
		endcase
	endfunction

endpackage

`default_nettype wire

// ===== design/ir_rlc_prep.sv =====
// Segment selection and numerator and denominator preparation for the divider.
`default_nettype none

module ir_rlc_prep (
	input  wire logic                           clk,
	input  wire logic                           load,
	input  wire logic [ir_rlc_pkg::ADC_W-1:0]   adc_sample,
	input  wire logic                           ext,
	output logic      [ir_rlc_pkg::NUM_W-1:0]   num_q,
	output logic      [ir_rlc_pkg::DEN_W-1:0]   den_q,
	output logic                                den_bad_q
);

	logic [ir_rlc_pkg::PROD_W-1:0] volt_prod;
	ir_rlc_pkg::seg_t              seg;
	logic [ir_rlc_pkg::DEN_W-1:0]  pos_part;
	logic [ir_rlc_pkg::NEG_W-1:0]  neg_part;
	logic [ir_rlc_pkg::DEN_W:0]    den_diff;

	always_comb begin
		volt_prod = ir_rlc_pkg::PROD_W'(adc_sample) * ir_rlc_pkg::PROD_W'(500);
		seg = ir_rlc_pkg::seg_t'(ir_rlc_pkg::SEG_COUNT - 1);
		for (int i = ir_rlc_pkg::SEG_COUNT - 2; i >= 0; i--) begin
			if (volt_prod < ir_rlc_pkg::PROD_W'(ir_rlc_pkg::seg_limit_fs(
					ir_rlc_pkg::seg_t'(i), ext))) begin
				seg = ir_rlc_pkg::seg_t'(i);
			end
		end
		pos_part = {13'(adc_sample) * 13'd5, 16'd0};
		neg_part = ir_rlc_pkg::seg_neg(seg, ext);
		den_diff = {1'b0, pos_part} - (ir_rlc_pkg::DEN_W + 1)'(neg_part);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			num_q     <= ir_rlc_pkg::seg_num(seg, ext);
			den_q     <= den_diff[ir_rlc_pkg::DEN_W-1:0];
			den_bad_q <= (pos_part <= ir_rlc_pkg::DEN_W'(neg_part));
		end
	end

endmodule

`default_nettype wire

// ===== design/ir_rlc_div.sv =====
// Restoring divider that yields one quotient bit per cycle with overflow detection.
`default_nettype none
`include "ir_range_linearize_classify_macros.svh"

module ir_rlc_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [ir_rlc_pkg::NUM_W-1:0]   num,
	input  wire logic [ir_rlc_pkg::DEN_W-1:0]   den,
	input  wire logic                           den_bad,
	output ir_rlc_pkg::div_stat_t               stat,
	output logic      [ir_rlc_pkg::QUO_W-1:0]   quotient
);

	localparam int SHIFT_W = ir_rlc_pkg::QUO_W - 16;

	ir_rlc_pkg::div_state_t state_q, state_d;

	logic [ir_rlc_pkg::DEN_W-1:0] rem_q;
	logic [ir_rlc_pkg::QUO_W-1:0] low_q;
	logic [ir_rlc_pkg::QUO_W-1:0] quo_q;
	logic [ir_rlc_pkg::CNT_W-1:0] cnt_q;
	logic                         sat_q;

	logic                         overflow;
	logic [ir_rlc_pkg::DEN_W:0]   trial;
	logic [ir_rlc_pkg::DEN_W+1:0] diff;
	logic                         fits;

	always_comb begin
		overflow = den_bad ||
			({5'd0, num} >= {den, (ir_rlc_pkg::QUO_W - 16)'(0)});
		trial = {rem_q, low_q[ir_rlc_pkg::QUO_W-1]};
		diff  = {1'b0, trial} - (ir_rlc_pkg::DEN_W + 2)'(den);
		fits  = !diff[ir_rlc_pkg::DEN_W+1];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ir_rlc_pkg::D_IDLE: begin
				if (start) begin
					state_d = ir_rlc_pkg::D_CHECK;
				end
			end
			ir_rlc_pkg::D_CHECK: begin
				state_d = overflow ? ir_rlc_pkg::D_DONE : ir_rlc_pkg::D_ITER;
			end
			ir_rlc_pkg::D_ITER: begin
				if (cnt_q == '0) begin
					state_d = ir_rlc_pkg::D_DONE;
				end
			end
			ir_rlc_pkg::D_DONE: begin
				state_d = ir_rlc_pkg::D_IDLE;
			end
			default: begin
				state_d = ir_rlc_pkg::D_IDLE;
			end
		endcase
	end

	always_comb begin
		stat.idle = (state_q == ir_rlc_pkg::D_IDLE);
		stat.done = (state_q == ir_rlc_pkg::D_DONE);
		stat.sat  = sat_q;
		quotient  = quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ir_rlc_pkg::D_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ir_rlc_pkg::D_CHECK: begin
				sat_q <= overflow;
				rem_q <= ir_rlc_pkg::DEN_W'(num[ir_rlc_pkg::NUM_W-1:SHIFT_W]);
				low_q <= {num[SHIFT_W-1:0], 16'd0};
				quo_q <= '0;
				cnt_q <= ir_rlc_pkg::CNT_W'(ir_rlc_pkg::QUO_W - 1);
			end
			ir_rlc_pkg::D_ITER: begin
				rem_q <= fits ? diff[ir_rlc_pkg::DEN_W-1:0] : trial[ir_rlc_pkg::DEN_W-1:0];
				low_q <= {low_q[ir_rlc_pkg::QUO_W-2:0], 1'b0};
				quo_q <= {quo_q[ir_rlc_pkg::QUO_W-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	`IR_RLC_ASSERT_NOW(a_start_when_idle, clk, arst_n, start,
		state_q == ir_rlc_pkg::D_IDLE, "Divider started while busy.")
	`IR_RLC_ASSERT_NOW(a_rem_below_den, clk, arst_n, state_q == ir_rlc_pkg::D_ITER,
		rem_q < den, "Partial remainder is not below the denominator.")
	`IR_RLC_ASSERT_NEXT(a_done_to_idle, clk, arst_n, state_q == ir_rlc_pkg::D_DONE,
		state_q == ir_rlc_pkg::D_IDLE, "Divider did not return to idle after finishing.")

endmodule

`default_nettype wire

// ===== design/ir_range_linearize_classify.sv =====
// Top level of the IR range linearizer and proximity classifier.
`default_nettype none
`include "ir_range_linearize_classify_macros.svh"

// One sample at a time: in_ready is high only while the block is idle, and an
// accepted sample is prepared into registers and then divided by the restoring
// divider, which produces one of 27 quotient bits per cycle and skips its
// iterations when the denominator is not positive or the quotient is out of
// range; a result waiting in the output register does not hold off the next
// sample until that result is needed to be replaced.
module ir_range_linearize_classify #(
	parameter int POSITION_COUNT = 3
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [ir_rlc_pkg::ADC_W-1:0]     adc_sample,
	input  wire logic                             converter_kind,
	input  wire logic [ir_rlc_pkg::POS_W-1:0]     sensor_position,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic      [ir_rlc_pkg::DIST_W-1:0]    distance_cm,
	output logic      [ir_rlc_pkg::STAT_W-1:0]    proximity_status,
	output logic      [ir_rlc_pkg::POS_W-1:0]     echo_position,
	output logic                                  distance_changed,
	output logic                                  status_changed,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [ir_rlc_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [ir_rlc_pkg::DIST_W-1:0]    cfg_data
);

	ir_rlc_pkg::ctrl_state_t state_q, state_d;

	logic [ir_rlc_pkg::ADC_W-1:0]  adc_q;
	logic                          ext_q;
	logic [ir_rlc_pkg::POS_W-1:0]  pos_q;
	logic [ir_rlc_pkg::DIST_W-1:0] dist_q;
	logic [ir_rlc_pkg::DIST_W-1:0] bound_ok_q, bound_warning_q, bound_danger_q;
	logic [ir_rlc_pkg::DIST_W-1:0] last_dist_q [POSITION_COUNT];
	logic [ir_rlc_pkg::STAT_W-1:0] last_stat_q [POSITION_COUNT];

	logic                          out_valid_q;
	logic [ir_rlc_pkg::DIST_W-1:0] out_dist_q;
	logic [ir_rlc_pkg::STAT_W-1:0] out_stat_q;
	logic [ir_rlc_pkg::POS_W-1:0]  out_pos_q;
	logic                          out_dchg_q, out_schg_q;

	logic                          in_accept, prep_load, div_start, out_free, out_load;
	logic [ir_rlc_pkg::NUM_W-1:0]  num;
	logic [ir_rlc_pkg::DEN_W-1:0]  den;
	logic                          den_bad;
	ir_rlc_pkg::div_stat_t         div_stat;
	logic [ir_rlc_pkg::QUO_W-1:0]  quotient;

	logic [ir_rlc_pkg::QUO_W-1:0]  q_off;
	logic [ir_rlc_pkg::DIST_W-1:0] fin_dist;
	logic [ir_rlc_pkg::STAT_W-1:0] stat;
	logic                          in_range;
	logic [ir_rlc_pkg::DIST_W-1:0] prev_dist;
	logic [ir_rlc_pkg::STAT_W-1:0] prev_stat;

	ir_rlc_prep u_prep (
		.clk        (clk),
		.load       (prep_load),
		.adc_sample (adc_q),
		.ext        (ext_q),
		.num_q      (num),
		.den_q      (den),
		.den_bad_q  (den_bad)
	);

	ir_rlc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (num),
		.den      (den),
		.den_bad  (den_bad),
		.stat     (div_stat),
		.quotient (quotient)
	);

	assign out_free  = !out_valid_q || out_ready;
	assign in_accept = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ir_rlc_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = ir_rlc_pkg::S_PREP;
				end
			end
			ir_rlc_pkg::S_PREP: begin
				state_d = ir_rlc_pkg::S_WAIT;
			end
			ir_rlc_pkg::S_WAIT: begin
				if (div_stat.done) begin
					state_d = ir_rlc_pkg::S_OUT;
				end
			end
			ir_rlc_pkg::S_OUT: begin
				if (out_free) begin
					state_d = ir_rlc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ir_rlc_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ir_rlc_pkg::S_IDLE);
		prep_load = (state_q == ir_rlc_pkg::S_PREP);
		div_start = (state_q == ir_rlc_pkg::S_PREP);
		out_load  = (state_q == ir_rlc_pkg::S_OUT) && out_free;
	end

	// Removes the 0.42 offset from the Q16 quotient and saturates.
	always_comb begin
		q_off = quotient - ir_rlc_pkg::Q16_OFFSET;
		priority if (div_stat.sat) begin
			fin_dist = ir_rlc_pkg::DIST_MAX;
		end else if (quotient < ir_rlc_pkg::Q16_OFFSET) begin
			fin_dist = '0;
		end else if (q_off[ir_rlc_pkg::QUO_W-1:16] > 11'(ir_rlc_pkg::DIST_MAX)) begin
			fin_dist = ir_rlc_pkg::DIST_MAX;
		end else begin
			fin_dist = q_off[16 +: ir_rlc_pkg::DIST_W];
		end
	end

	always_comb begin
		priority if (dist_q >= bound_ok_q) begin
			stat = ir_rlc_pkg::STAT_OK;
		end else if (dist_q >= bound_warning_q) begin
			stat = ir_rlc_pkg::STAT_WARNING;
		end else if (dist_q >= bound_danger_q) begin
			stat = ir_rlc_pkg::STAT_DANGER;
		end else begin
			stat = ir_rlc_pkg::STAT_NONE;
		end
	end

	always_comb begin
		in_range  = int'(pos_q) < POSITION_COUNT;
		prev_dist = '0;
		prev_stat = ir_rlc_pkg::STAT_NONE;
		for (int i = 0; i < POSITION_COUNT; i++) begin
			if (int'(pos_q) == i) begin
				prev_dist = last_dist_q[i];
				prev_stat = last_stat_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ir_rlc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_ok_q      <= ir_rlc_pkg::BOUND_OK_RESET;
			bound_warning_q <= ir_rlc_pkg::BOUND_WARNING_RESET;
			bound_danger_q  <= ir_rlc_pkg::BOUND_DANGER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ir_rlc_pkg::REG_BOUND_OK:      bound_ok_q      <= cfg_data;
				ir_rlc_pkg::REG_BOUND_WARNING: bound_warning_q <= cfg_data;
				ir_rlc_pkg::REG_BOUND_DANGER:  bound_danger_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			adc_q <= adc_sample;
			ext_q <= converter_kind;
			pos_q <= sensor_position;
		end
		if (state_q == ir_rlc_pkg::S_WAIT && div_stat.done) begin
			dist_q <= fin_dist;
		end
		if (out_load) begin
			out_dist_q <= dist_q;
			out_stat_q <= stat;
			out_pos_q  <= pos_q;
			out_dchg_q <= in_range && (dist_q != prev_dist);
			out_schg_q <= in_range && (stat != prev_stat);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POSITION_COUNT; i++) begin
				last_dist_q[i] <= '0;
				last_stat_q[i] <= ir_rlc_pkg::STAT_NONE;
			end
		end else if (out_load && in_range) begin
			for (int i = 0; i < POSITION_COUNT; i++) begin
				if (int'(pos_q) == i) begin
					last_dist_q[i] <= dist_q;
					last_stat_q[i] <= stat;
				end
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign distance_cm      = out_dist_q;
	assign proximity_status = out_stat_q;
	assign echo_position    = out_pos_q;
	assign distance_changed = out_dchg_q;
	assign status_changed   = out_schg_q;

	`IR_RLC_ASSERT_NOW(a_idle_divider, clk, arst_n, state_q == ir_rlc_pkg::S_IDLE,
		div_stat.idle, "Controller is idle while the divider is busy.")
	`IR_RLC_ASSERT_NOW(a_flags_out_of_range, clk, arst_n,
		out_valid_q && (int'(out_pos_q) >= POSITION_COUNT),
		!out_dchg_q && !out_schg_q, "Change flag set for a position without history.")
	`IR_RLC_ASSERT_NEXT(a_history_update, clk, arst_n, out_load && in_range,
		prev_dist == $past(dist_q), "History entry not updated with the delivered distance.")

endmodule

`default_nettype wire

// ===== dv/tb_ir_range_linearize_classify.sv =====
// Self-checking testbench for the IR range linearizer and proximity classifier.
module tb_ir_range_linearize_classify;
	import ir_rlc_pkg::*;

	localparam int POSITIONS = 3;
	localparam int PHASES = 8;
	localparam int SAMPLES_PER_PHASE = 200;
	localparam int TAIL_CYCLES = 40;
	localparam int unsigned CYCLE_LIMIT = 800000;

	localparam logic KIND_INTERNAL = 1'b0;
	localparam logic KIND_EXTERNAL = 1'b1;
	localparam logic [POS_W-1:0] POS_LEFT   = 2'd0;
	localparam logic [POS_W-1:0] POS_CENTRE = 2'd1;
	localparam logic [POS_W-1:0] POS_RIGHT  = 2'd2;
	localparam logic [POS_W-1:0] POS_STRAY  = POS_W'(POSITIONS);
	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [STAT_W-1:0] stat;
		logic [POS_W-1:0]  pos;
		logic              dchg;
		logic              schg;
	} range_result_t;

	class range_scoreboard;
		longint unsigned lim_hv[SEG_COUNT-1];
		longint unsigned gain_q16[SEG_COUNT];
		longint unsigned offset_q16[SEG_COUNT];
		logic [DIST_W-1:0] ok_min, warning_min, danger_min;
		logic [DIST_W-1:0] last_dist[POSITIONS];
		logic [STAT_W-1:0] last_stat[POSITIONS];
		range_result_t pending[$];
		int unsigned errors, samples, checked, writes, saturated, strays;

		function new();
			lim_hv = '{SEG_L0, SEG_L1, SEG_L2, SEG_L3, SEG_L4};
			gain_q16 = '{SEG_K0, SEG_K1, SEG_K2, SEG_K3, SEG_K4, SEG_K5};
			offset_q16 = '{SEG_C0, SEG_C1, SEG_C2, SEG_C3, SEG_C4, SEG_C5};
			ok_min = BOUND_OK_RESET;
			warning_min = BOUND_WARNING_RESET;
			danger_min = BOUND_DANGER_RESET;
			foreach (last_dist[i]) begin
				last_dist[i] = '0;
				last_stat[i] = STAT_NONE;
			end
		endfunction

		function void set_bound(logic [IDX_W-1:0] idx, logic [DIST_W-1:0] val);
			case (idx)
				REG_BOUND_OK: ok_min = val;
				REG_BOUND_WARNING: warning_min = val;
				REG_BOUND_DANGER: danger_min = val;
				default: ;
			endcase
			writes++;
		endfunction

		function logic [DIST_W-1:0] linear_distance(logic [ADC_W-1:0] adc, logic ext);
			longint unsigned fs, num, scaled, offset, quo;
			int s;
			fs = (ext == KIND_EXTERNAL) ? FS_EXTERNAL : FS_INTERNAL;
			s = 0;
			while (s < SEG_COUNT - 1 && 64'(adc) * 64'd500 >= lim_hv[s] * fs)
				s++;
			num = gain_q16[s] * fs;
			scaled = (64'(adc) * 64'd5) << 16;
			offset = offset_q16[s] * fs;
			if (scaled <= offset)
				return DIST_MAX;
			quo = (num << 16) / (scaled - offset);
			if (quo < 64'(Q16_OFFSET))
				return '0;
			quo = (quo - 64'(Q16_OFFSET)) >> 16;
			return (quo > 64'(DIST_MAX)) ? DIST_MAX : quo[DIST_W-1:0];
		endfunction

		function logic [STAT_W-1:0] proximity_of(logic [DIST_W-1:0] distance);
			if (distance >= ok_min)
				return STAT_OK;
			if (distance >= warning_min)
				return STAT_WARNING;
			if (distance >= danger_min)
				return STAT_DANGER;
			return STAT_NONE;
		endfunction

		function void note_sample(logic [ADC_W-1:0] adc, logic ext, logic [POS_W-1:0] pos);
			range_result_t r;
			r.distance = linear_distance(adc, ext);
			r.stat = proximity_of(r.distance);
			r.pos = pos;
			r.dchg = 1'b0;
			r.schg = 1'b0;
			if (pos < POSITIONS) begin
				r.dchg = (r.distance != last_dist[pos]);
				r.schg = (r.stat != last_stat[pos]);
				last_dist[pos] = r.distance;
				last_stat[pos] = r.stat;
			end else begin
				strays++;
			end
			if (r.distance == DIST_MAX)
				saturated++;
			pending.push_back(r);
			samples++;
		endfunction

		function void compare_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(range_result_t got);
			range_result_t want;
			if (pending.size() == 0) begin
				$display("%0t: result with nothing expected: distance %0d status %0d position %0d",
					$time, got.distance, got.stat, got.pos);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			compare_field("distance_cm", want.distance, got.distance);
			compare_field("proximity_status", want.stat, got.stat);
			compare_field("echo_position", want.pos, got.pos);
			compare_field("distance_changed", want.dchg, got.dchg);
			compare_field("status_changed", want.schg, got.schg);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [ADC_W-1:0] adc_sample = '0;
	logic converter_kind = KIND_INTERNAL;
	logic [POS_W-1:0] sensor_position = POS_LEFT;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [DIST_W-1:0] distance_cm;
	logic [STAT_W-1:0] proximity_status;
	logic [POS_W-1:0] echo_position;
	logic distance_changed;
	logic status_changed;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = REG_BOUND_OK;
	logic [DIST_W-1:0] cfg_data = '0;

	range_scoreboard sb = new();
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int unsigned rx_hold = 0;
	int unsigned rx_stretch = 0;
	logic [ADC_W-1:0] sent_adc[4] = '{default: '0};
	logic sent_kind[4] = '{default: KIND_INTERNAL};

	ir_range_linearize_classify #(.POSITION_COUNT(POSITIONS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.adc_sample(adc_sample),
		.converter_kind(converter_kind),
		.sensor_position(sensor_position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.distance_cm(distance_cm),
		.proximity_status(proximity_status),
		.echo_position(echo_position),
		.distance_changed(distance_changed),
		.status_changed(status_changed),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic int unsigned idle_span();
		if (tx_steady || $urandom_range(0, 99) < 55)
			return 0;
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 4);
		return $urandom_range(10, 45);
	endfunction

	// First sample that falls into segment s + 1 for the given converter.
	function automatic logic [ADC_W-1:0] seg_entry(int s, logic ext);
		longint unsigned fs;
		fs = (ext == KIND_EXTERNAL) ? FS_EXTERNAL : FS_INTERNAL;
		return ADC_W'((sb.lim_hv[s] * fs + 64'd499) / 64'd500);
	endfunction

	// Called right after the previous transfer, so valid is either updated
	// or lowered at the next falling edge, before the block can take it twice.
	task automatic send_sample(input logic [ADC_W-1:0] a, input logic k,
		input logic [POS_W-1:0] p);
		int unsigned gap;
		gap = idle_span();
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		adc_sample <= a;
		converter_kind <= k;
		sensor_position <= p;
		do @(posedge clk); while (!in_ready);
		sb.note_sample(a, k, p);
		sent_adc[p] = a;
		sent_kind[p] = k;
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task automatic write_bound(input logic [IDX_W-1:0] idx, input logic [DIST_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_bound(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic pick_sample(output logic [ADC_W-1:0] a, output logic k,
		output logic [POS_W-1:0] p);
		int unsigned r;
		r = $urandom_range(0, 99);
		p = ($urandom_range(0, 99) < 8) ? POS_STRAY : POS_W'($urandom_range(0, POSITIONS - 1));
		k = 1'($urandom_range(0, 1));
		if (r < 12) begin
			a = sent_adc[p];
			k = sent_kind[p];
		end else if (r < 40) begin
			a = ADC_W'($urandom_range(0, 1023));
		end else if (r < 70) begin
			a = ADC_W'((k == KIND_EXTERNAL) ? $urandom_range(0, 90) : $urandom_range(0, 350));
		end else begin
			a = seg_entry($urandom_range(0, SEG_COUNT - 2), k) + ADC_W'($urandom_range(0, 4))
				- ADC_W'(2);
		end
	endtask

	always @(negedge clk) begin
		if (rx_stretch == 0) begin
			rx_steady = ($urandom_range(0, 3) == 0);
			rx_stretch = $urandom_range(40, 400);
		end
		rx_stretch--;
		if (rx_hold != 0) begin
			rx_hold--;
			out_ready <= 1'b0;
		end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
			rx_hold = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 45);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({distance_cm, proximity_status, echo_position,
				distance_changed, status_changed});
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Run stopped after %0d cycles with %0d results outstanding.",
			cycles, sb.pending.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		logic [ADC_W-1:0] a;
		logic k;
		logic [POS_W-1:0] p;
		logic [DIST_W-1:0] ok_b, warn_b, dang_b;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Reset bounds: converter extremes, saturation, stray position, repeats, segment edges.
		send_sample('0, KIND_INTERNAL, POS_LEFT);
		send_sample(ADC_W'(21), KIND_INTERNAL, POS_CENTRE);
		send_sample('1, KIND_INTERNAL, POS_RIGHT);
		send_sample('0, KIND_EXTERNAL, POS_STRAY);
		send_sample('1, KIND_EXTERNAL, POS_LEFT);
		send_sample('1, KIND_EXTERNAL, POS_LEFT);
		for (int s = 0; s < SEG_COUNT - 1; s++) begin
			for (int kk = 0; kk < 2; kk++) begin
				a = seg_entry(s, 1'(kk));
				send_sample(a - ADC_W'(1), 1'(kk), POS_W'(s % POSITIONS));
				send_sample(a, 1'(kk), POS_W'((s + 1) % POSITIONS));
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: begin ok_b = '0; warn_b = '0; dang_b = '0; end
				1: begin ok_b = '1; warn_b = '1; dang_b = '1; end
				2: begin ok_b = 10'd10; warn_b = 10'd20; dang_b = 10'd30; end
				3: begin ok_b = '1; warn_b = 10'd1; dang_b = '0; end
				default: begin
					dang_b = DIST_W'($urandom_range(0, 40));
					warn_b = dang_b + DIST_W'($urandom_range(0, 40));
					ok_b = warn_b + DIST_W'($urandom_range(0, 60));
				end
			endcase
			write_bound(REG_BOUND_OK, ok_b);
			write_bound(REG_BOUND_WARNING, warn_b);
			write_bound(REG_BOUND_DANGER, dang_b);
			if (ph == 1)
				write_bound(REG_UNUSED, DIST_W'($urandom_range(0, 1023)));
			for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
				if (n % 64 == 0)
					tx_steady = ($urandom_range(0, 3) == 0);
				pick_sample(a, k, p);
				send_sample(a, k, p);
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Checked %0d results from %0d samples over %0d bound settings (%0d writes).",
			sb.checked, sb.samples, PHASES + 1, sb.writes);
		$display("Saturated distances: %0d; samples on an unused position: %0d.",
			sb.saturated, sb.strays);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
